// ===== hw/rtl/mle_pkg.sv =====
// ----------------------------------------------------------------------------
// mle_pkg: shared types and constants of the masked line editor
// Result kinds, console byte codes, register map and the line store request.
// ----------------------------------------------------------------------------
`default_nettype none

package mle_pkg;

	// Width of the character count, the limit register and line_length.
	localparam int CNT_W = 6;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MAX_CHARS = 1'b0;
	localparam logic [CNT_W-1:0] MAX_CHARS_RST = 6'd30;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ABORT = 2'd3;

	// Console byte codes.
	localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
	localparam logic [BYTE_W-1:0] CH_ETX  = 8'h03;
	localparam logic [BYTE_W-1:0] CH_BEL  = 8'h07;
	localparam logic [BYTE_W-1:0] CH_BS   = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_DEL  = 8'h7F;

	// Access to the line store; addresses are sliced to the store depth.
	typedef struct packed {
		logic              we;
		logic [CNT_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [CNT_W-1:0]  raddr;
	} mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mle_if.sv =====
// ----------------------------------------------------------------------------
// mle_if: stream channels of the masked line editor
// Input channel with one console byte and result channel with one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mle_rx_if;
	logic                           valid;
	logic                           ready;
	logic [mle_pkg::BYTE_W-1:0]     rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mle_res_if;
	logic                           valid;
	logic                           ready;
	logic [mle_pkg::BYTE_W-1:0]     out_byte;
	logic [mle_pkg::KIND_W-1:0]     out_kind;
	logic [mle_pkg::CNT_W-1:0]      line_length;
	logic                           last;

	modport source (output valid, output out_byte, output out_kind,
		output line_length, output last, input ready);
	modport sink (input valid, input out_byte, input out_kind,
		input line_length, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/masked_line_editor.sv =====
// Answers: a stored, belled or abort byte loads its word into the output
// register when it is free, else via the echo state; erase gives three words.
// Throughput: one byte per cycle for ordinary bytes while the output is free;
// enter gives CR, LF, a registered read plus data word per character, then DONE.
// Reset (arst_n low, asynchronous): empty line, max_chars back to 30, no word
// pending. The line store itself is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
// masked_line_editor: console line editor with masked echo
// Edits a hidden line from console bytes, echoes '*' per stored character and
// delivers the line on enter.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_line_editor #(
	parameter int LINE_DEPTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mle_rx_if.sink                             rx,
	mle_res_if.source                          tx,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mle_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mle_pkg::PDATA_W-1:0]   pwdata,
	output logic      [mle_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);

	// Address width of the line store.
	localparam int AW = $clog2(LINE_DEPTH);

	logic [mle_pkg::CNT_W-1:0]  max_chars;
	mle_pkg::mem_req_t          mem_req;
	logic [mle_pkg::BYTE_W-1:0] mem_rdata;

	// Limit register; user must write it only while the editor is idle (unenforced).
	mle_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.max_chars (max_chars)
	);

	// The sequencer owns the character count and the output register. It
	// writes a stored byte in the cycle the byte is accepted, and on enter
	// reads the line back one entry at a time. No new byte is taken until a
	// drain is over, so a read never meets a write to the same entry.
	mle_seq #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_chars (max_chars),
		.rx        (rx),
		.tx        (tx),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// The hidden line itself.
	mle_ram #(
		.WIDTH (mle_pkg::BYTE_W),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr[AW-1:0]),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr[AW-1:0]),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mle_ram.sv =====
// ----------------------------------------------------------------------------
// mle_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module mle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mle_cfg.sv =====
// ----------------------------------------------------------------------------
// mle_cfg: configuration register file
// APB-style access to the character limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module mle_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mle_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mle_pkg::PDATA_W-1:0]   pwdata,
	output logic      [mle_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output logic      [mle_pkg::CNT_W-1:0]     max_chars
);

	logic [mle_pkg::CNT_W-1:0] max_chars_q;
	logic                      wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr[2] == mle_pkg::REG_MAX_CHARS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= mle_pkg::MAX_CHARS_RST;
		end else if (wr_en) begin
			max_chars_q <= pwdata[mle_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == mle_pkg::REG_MAX_CHARS) begin
			prdata = {{(mle_pkg::PDATA_W-mle_pkg::CNT_W){1'b0}}, max_chars_q};
		end
	end

	assign max_chars = max_chars_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mle_seq.sv =====
// ----------------------------------------------------------------------------
// mle_seq: line editing sequencer
// Classifies console bytes, keeps the character count, drives the line
// store and emits echo, data and status words through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mle_seq #(
	parameter int LINE_DEPTH = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [mle_pkg::CNT_W-1:0] max_chars,
	mle_rx_if.sink                         rx,
	mle_res_if.source                      tx,
	output mle_pkg::mem_req_t              mem_req,
	input  wire logic [mle_pkg::BYTE_W-1:0] mem_rdata
);

	localparam logic [mle_pkg::CNT_W-1:0] DEPTH_C = mle_pkg::CNT_W'(LINE_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ECHO = 5'b00010,
		S_READ = 5'b00100,
		S_DATA = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		OP_STAR,
		OP_BELL,
		OP_ABORT,
		OP_ERASE,
		OP_ENTER
	} op_t;

	typedef enum logic [2:0] {
		CL_IGNORE,
		CL_ENTER,
		CL_ABORT,
		CL_ERASE,
		CL_STORE
	} cls_t;

	state_t                      state_q, state_d;
	op_t                         op_q, op_d;
	logic [1:0]                  step_q, step_d;
	logic [mle_pkg::CNT_W-1:0]   count_q, count_d;
	logic [mle_pkg::CNT_W-1:0]   idx_q, idx_d;
	logic [mle_pkg::CNT_W-1:0]   len_q, len_d;

	logic                        ovalid_q;
	logic [mle_pkg::BYTE_W-1:0]  obyte_q;
	logic [mle_pkg::KIND_W-1:0]  okind_q;
	logic [mle_pkg::CNT_W-1:0]   olen_q;
	logic                        olast_q;

	logic                        ld;
	logic [mle_pkg::BYTE_W-1:0]  ld_byte;
	logic [mle_pkg::KIND_W-1:0]  ld_kind;
	logic [mle_pkg::CNT_W-1:0]   ld_len;
	logic                        ld_last;

	logic [mle_pkg::CNT_W-1:0]   limit;
	logic                        out_free;
	logic                        acc;
	cls_t                        cls;
	op_t                         single_op;
	logic                        single;

	assign limit    = (max_chars > DEPTH_C) ? DEPTH_C : max_chars;
	assign out_free = !ovalid_q || tx.ready;
	assign rx.ready = (state_q == S_IDLE);
	assign acc      = rx.valid && rx.ready;

	always_comb begin
		unique case (rx.rx_byte)
			mle_pkg::CH_NUL, mle_pkg::CH_TAB: cls = CL_IGNORE;
			mle_pkg::CH_CR, mle_pkg::CH_LF:   cls = CL_ENTER;
			mle_pkg::CH_ETX:                  cls = CL_ABORT;
			mle_pkg::CH_BS, mle_pkg::CH_DEL:  cls = CL_ERASE;
			default:                          cls = CL_STORE;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		step_d    = step_q;
		count_d   = count_q;
		idx_d     = idx_q;
		len_d     = len_q;
		ld        = 1'b0;
		ld_byte   = '0;
		ld_kind   = mle_pkg::KIND_ECHO;
		ld_len    = '0;
		ld_last   = 1'b0;
		single    = 1'b0;
		single_op = OP_STAR;
		mem_req   = '0;
		mem_req.waddr = count_q;
		mem_req.wdata = rx.rx_byte;
		mem_req.raddr = idx_q;

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (cls)
						CL_IGNORE: begin
						end
						CL_ENTER: begin
							len_d   = count_q;
							count_d = '0;
							idx_d   = '0;
							step_d  = '0;
							op_d    = OP_ENTER;
							state_d = S_ECHO;
						end
						CL_ABORT: begin
							count_d   = '0;
							single    = 1'b1;
							single_op = OP_ABORT;
						end
						CL_ERASE: begin
							if (count_q != '0) begin
								count_d = count_q - 1'b1;
								step_d  = '0;
								op_d    = OP_ERASE;
								state_d = S_ECHO;
							end
						end
						CL_STORE: begin
							single = 1'b1;
							if (count_q < limit) begin
								mem_req.we = 1'b1;
								count_d    = count_q + 1'b1;
								single_op  = OP_STAR;
							end else begin
								single_op  = OP_BELL;
							end
						end
						default: begin
						end
					endcase
				end
				// A one-word answer goes straight to the output register when
				// it is free; otherwise it waits in the echo state.
				if (single) begin
					if (out_free) begin
						ld      = 1'b1;
						ld_last = 1'b1;
						if (single_op == OP_ABORT) begin
							ld_kind = mle_pkg::KIND_ABORT;
						end else if (single_op == OP_BELL) begin
							ld_byte = mle_pkg::CH_BEL;
						end else begin
							ld_byte = mle_pkg::CH_STAR;
						end
					end else begin
						op_d    = single_op;
						step_d  = '0;
						state_d = S_ECHO;
					end
				end
			end
			S_ECHO: begin
				if (out_free) begin
					ld = 1'b1;
					unique case (op_q)
						OP_STAR: begin
							ld_byte = mle_pkg::CH_STAR;
							ld_last = 1'b1;
							state_d = S_IDLE;
						end
						OP_BELL: begin
							ld_byte = mle_pkg::CH_BEL;
							ld_last = 1'b1;
							state_d = S_IDLE;
						end
						OP_ABORT: begin
							ld_kind = mle_pkg::KIND_ABORT;
							ld_last = 1'b1;
							state_d = S_IDLE;
						end
						OP_ERASE: begin
							ld_byte = (step_q == 2'd1) ? mle_pkg::CH_SP : mle_pkg::CH_BS;
							ld_last = (step_q == 2'd2);
							step_d  = step_q + 1'b1;
							if (step_q == 2'd2) begin
								state_d = S_IDLE;
							end
						end
						OP_ENTER: begin
							ld_byte = (step_q == 2'd0) ? mle_pkg::CH_CR : mle_pkg::CH_LF;
							step_d  = step_q + 1'b1;
							if (step_q != 2'd0) begin
								state_d = (len_q == '0) ? S_DONE : S_READ;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				mem_req.re = 1'b1;
				state_d    = S_DATA;
			end
			S_DATA: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_byte = mem_rdata;
					ld_kind = mle_pkg::KIND_DATA;
					idx_d   = idx_q + 1'b1;
					state_d = (idx_q + 1'b1 == len_q) ? S_DONE : S_READ;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_kind = mle_pkg::KIND_DONE;
					ld_len  = len_q;
					ld_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_STAR;
			step_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			len_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			op_q     <= op_d;
			step_q   <= step_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			len_q    <= len_d;
			if (ld) begin
				ovalid_q <= 1'b1;
			end else if (tx.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			obyte_q <= ld_byte;
			okind_q <= ld_kind;
			olen_q  <= ld_len;
			olast_q <= ld_last;
		end
	end

	assign tx.valid       = ovalid_q;
	assign tx.out_byte    = obyte_q;
	assign tx.out_kind    = okind_q;
	assign tx.line_length = olen_q;
	assign tx.last        = olast_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mle_checker.sv =====
// ----------------------------------------------------------------------------
// mle_checker: port-level checks of the masked line editor
// Watches the stream ports and flags malformed or misordered result words.
// ----------------------------------------------------------------------------
`default_nettype none

module mle_checker #(
	parameter int LINE_DEPTH = 32
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         rx_ready,
	input wire logic                         tx_valid,
	input wire logic                         tx_ready,
	input wire logic [mle_pkg::BYTE_W-1:0]   tx_out_byte,
	input wire logic [mle_pkg::KIND_W-1:0]   tx_out_kind,
	input wire logic [mle_pkg::CNT_W-1:0]    tx_line_length,
	input wire logic                         tx_last
);

	// A stalled result word stays put.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_byte)
			&& $stable(tx_out_kind) && $stable(tx_line_length) && $stable(tx_last))
		else $error("result word changed while stalled");

	// Status words close a sequence, carry no byte, and a line fits the store.
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (tx_out_kind == mle_pkg::KIND_DONE || tx_out_kind == mle_pkg::KIND_ABORT)
			|-> tx_last && tx_out_byte == '0
			&& tx_line_length <= mle_pkg::CNT_W'(LINE_DEPTH))
		else $error("malformed status word");

	// Line data is always followed by more words of the same sequence.
	a_data_form: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_out_kind == mle_pkg::KIND_DATA |-> !tx_last && tx_line_length == '0)
		else $error("malformed line data word");

	// While a word that is not the last of its answer waits, no new console
	// byte is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_last |-> !rx_ready)
		else $error("input taken in the middle of an answer");

endmodule

bind masked_line_editor mle_checker #(
	.LINE_DEPTH (LINE_DEPTH)
) u_mle_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_ready       (rx.ready),
	.tx_valid       (tx.valid),
	.tx_ready       (tx.ready),
	.tx_out_byte    (tx.out_byte),
	.tx_out_kind    (tx.out_kind),
	.tx_line_length (tx.line_length),
	.tx_last        (tx.last)
);

`default_nettype wire
